// ===== rtl/pool2d_pkg.sv =====
// Shared constants, state and register codes, and divider request and response types of the pooling block.
package pool2d_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int LINE_W       = 18;
  localparam int TOT_W        = 20;
  localparam int MAX_WINDOW   = 4;
  localparam int LANE_AW      = $clog2(MAX_WINDOW);
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 64;
  localparam int CFG_W        = 9;
  localparam int IDX_W        = 3;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP9       = 1864135;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [IDX_W-1:0] {
    REG_CHANNELS = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_WINDOW   = 3'd3,
    REG_STEP     = 3'd4,
    REG_MODE     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                    valid;
    logic [2:0]              win;
    logic signed [TOT_W-1:0] total;
  } div_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/pool2d_linemem.sv =====
// Line buffer memory: one word per output column, one lane per buffered row.
module pool2d_linemem #(
  parameter int DEPTH  = pool2d_pkg::MAX_WIDTH,
  parameter int AW     = $clog2(DEPTH),
  parameter int WORD_W = pool2d_pkg::MAX_WINDOW * pool2d_pkg::LINE_W
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i
);
  import pool2d_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/pool2d_avgdiv.sv =====
// Two-stage divider of a window sum by the window area, truncating toward zero.
module pool2d_avgdiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pool2d_pkg::div_req_t req_i,
  output pool2d_pkg::div_rsp_t rsp_o
);
  import pool2d_pkg::*;

  logic                       neg;
  logic [TOT_W-1:0]           mag;
  logic [40:0]                prod;
  logic [TOT_W-1:0]           q0;
  logic                       v1_q, v2_q;
  logic [TOT_W-1:0]           q1_q, mag1_q;
  logic                       neg1_q, nine1_q;
  logic [TOT_W-1:0]           rem, q2;
  logic [TOT_W-1:0]           sq;
  logic signed [SAMPLE_W-1:0] quot_q;

  // Magnitude first, so that a floor quotient is a truncation toward zero.
  always_comb begin
    neg  = req_i.total[TOT_W-1];
    mag  = neg ? TOT_W'(-req_i.total) : TOT_W'(req_i.total);
    prod = 41'(mag) * 41'(RECIP9);
    case (req_i.win)
      3'd2:    q0 = mag >> 2;
      3'd3:    q0 = TOT_W'(prod[40:RECIP_SHIFT]);
      3'd4:    q0 = mag >> 4;
      default: q0 = mag;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= q0;
    mag1_q  <= mag;
    neg1_q  <= neg;
    nine1_q <= (req_i.win == 3'd3);
  end

  // The reciprocal estimate for nine is never more than one too small.
  always_comb begin
    rem = mag1_q - ((q1_q << 3) + q1_q);
    q2  = (nine1_q && (rem >= TOT_W'(9))) ? q1_q + TOT_W'(1) : q1_q;
    sq  = neg1_q ? TOT_W'(-q2) : q2;
  end

  always_ff @(posedge clk_i) begin
    quot_q <= sq[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  assign rsp_o.valid = v2_q;
  assign rsp_o.quot  = quot_q;

endmodule

// ===== rtl/pool2d_max_avg_stream.sv =====
// Top level of the streaming 2-D max and average pooling block.
// A tensor streams in one sample per request, plane after plane, each plane in raster
// order. For each whole square window (side and stride set by configuration) one result
// leaves once the window's bottom-right sample arrives: the maximum, or the sum divided
// by the window area truncated toward zero. Each sample first folds the newest window
// samples of its row into one value; that value is merged into a line buffer memory
// that holds one word per output column with one lane per buffered row, and the lanes
// of the window rows are folded down the column. A sample that ends no row segment
// leaves the sequencer idle; one that ends a row segment also waits for the line buffer
// read-modify-write, through the memory's registered read and the merge state; one that
// completes a window then passes the output state, in average mode after the divider
// wait state, and may wait for the output register to drain. While a result sits in the
// output register, the next sample is already taken in. A configuration write to any of
// the six registers returns the stream to plane 0, row 0, column 0. The line buffer needs
// no clearing: a read only touches lanes written earlier in the same plane.
module pool2d_max_avg_stream #(
  parameter int MAX_WIDTH = pool2d_pkg::MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pool2d_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [pool2d_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pool2d_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pool2d_pkg::SAMPLE_W-1:0] pooled_o,
  output logic [5:0]                             plane_index_o,
  output logic [7:0]                             out_row_o,
  output logic [7:0]                             out_col_o,
  output logic                                   tensor_end_o
);
  import pool2d_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WORD_W = MAX_WINDOW * LINE_W;

  // Configuration registers.
  logic [6:0] chans_q;
  logic [8:0] height_q, width_q;
  logic [2:0] win_q, step_q;
  logic       avg_q;

  // Effective, clamped settings.
  logic [6:0] chans;
  logic [8:0] h, w;
  logic [2:0] ws, ss;

  // Stream position.
  logic [8:0] col_q, row_q;
  logic [5:0] plane_q;
  logic       col_first_q, row_first_q;
  logic [9:0] emit_col_q, emit_row_q;
  logic [7:0] oc_q, orow_q;
  logic [9:0] exp_c, exp_r;
  logic       hit_c, hit_r, row_end, plane_end;
  logic       is_last;

  logic signed [SAMPLE_W-1:0] rw_q [MAX_WINDOW-1];
  logic signed [SAMPLE_W-1:0] lanes_in [MAX_WINDOW];
  logic signed [LINE_W-1:0]   row_sum, rowval;
  logic signed [SAMPLE_W-1:0] row_max;

  // Item registers between the accept and merge cycles.
  logic signed [LINE_W-1:0]   rowval_q;
  logic [LANE_AW-1:0]         lane_q;
  logic                       hitr_q, last_q;
  logic [5:0]                 plane_m_q;
  logic [7:0]                 orow_m_q, oc_m_q;
  logic signed [SAMPLE_W-1:0] res_q;

  state_e state_q, state_d;
  logic   accept, mem_rd, mem_wr, load_out;

  logic [WORD_W-1:0]        rd_data, wr_data;
  logic [31:0]              rd_ext, wr_ext;
  logic signed [LINE_W-1:0] lane_v [MAX_WINDOW];
  logic signed [TOT_W-1:0]  col_sum, tot;
  logic signed [LINE_W-1:0] col_max;
  logic [LANE_AW-1:0]       sel;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                       out_valid_q, tensor_end_q;
  logic signed [SAMPLE_W-1:0] pooled_q;
  logic [5:0]                 plane_out_q;
  logic [7:0]                 row_out_q, col_out_q;

  // Out-of-range settings fold onto the nearest legal value.
  always_comb begin
    chans = (chans_q == 7'd0) ? 7'd1 :
            (chans_q > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : chans_q;
    h     = (height_q == 9'd0) ? 9'd1 :
            (height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_q;
    w     = (width_q == 9'd0) ? 9'd1 :
            (32'(width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_q;
    ws    = (win_q == 3'd0) ? 3'd1 :
            (win_q > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : win_q;
    ss    = (step_q == 3'd0) ? 3'd1 : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q  <= 7'd1;
      height_q <= 9'd8;
      width_q  <= 9'd8;
      win_q    <= 3'd2;
      step_q   <= 3'd2;
      avg_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CHANNELS: chans_q  <= cfg_data_i[6:0];
        REG_HEIGHT:   height_q <= cfg_data_i;
        REG_WIDTH:    width_q  <= cfg_data_i;
        REG_WINDOW:   win_q    <= cfg_data_i[2:0];
        REG_STEP:     step_q   <= cfg_data_i[2:0];
        REG_MODE:     avg_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Window ends are tracked by expected column and row, so no division is needed.
  always_comb begin
    accept    = in_valid_i && !in_stall_o;
    exp_c     = col_first_q ? 10'(ws) - 10'd1 : emit_col_q;
    exp_r     = row_first_q ? 10'(ws) - 10'd1 : emit_row_q;
    hit_c     = ({1'b0, col_q} == exp_c);
    hit_r     = ({1'b0, row_q} == exp_r);
    row_end   = (col_q + 9'd1 >= w);
    plane_end = (row_q + 9'd1 >= h);
    is_last   = (7'(plane_q) + 7'd1 == chans) && (10'(row_q) + 10'(ss) >= 10'(h)) &&
                (10'(col_q) + 10'(ss) >= 10'(w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      col_first_q <= 1'b1;
      row_first_q <= 1'b1;
      emit_col_q  <= '0;
      emit_row_q  <= '0;
      oc_q        <= '0;
      orow_q      <= '0;
    end else if (cfg_we_i && (cfg_index_i <= REG_MODE)) begin
      col_q       <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      col_first_q <= 1'b1;
      row_first_q <= 1'b1;
      oc_q        <= '0;
      orow_q      <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_q       <= '0;
        col_first_q <= 1'b1;
        oc_q        <= '0;
        if (plane_end) begin
          row_q       <= '0;
          row_first_q <= 1'b1;
          orow_q      <= '0;
          plane_q     <= (7'(plane_q) + 7'd1 >= chans) ? 6'd0 : plane_q + 6'd1;
        end else begin
          row_q <= row_q + 9'd1;
          if (hit_r) begin
            row_first_q <= 1'b0;
            emit_row_q  <= exp_r + 10'(ss);
            orow_q      <= orow_q + 8'd1;
          end
        end
      end else begin
        col_q <= col_q + 9'd1;
        if (hit_c) begin
          col_first_q <= 1'b0;
          emit_col_q  <= exp_c + 10'(ss);
          oc_q        <= oc_q + 8'd1;
        end
      end
    end
  end

  // Row window: the newest samples of the stream, newest first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
        rw_q[k] <= '0;
      end
    end else if (accept) begin
      rw_q[0] <= sample_i;
      for (int k = 1; k < MAX_WINDOW - 1; k++) begin
        rw_q[k] <= rw_q[k-1];
      end
    end
  end

  always_comb begin
    lanes_in[0] = sample_i;
    for (int k = 1; k < MAX_WINDOW; k++) begin
      lanes_in[k] = rw_q[k-1];
    end
    row_sum = '0;
    row_max = {1'b1, {(SAMPLE_W-1){1'b0}}};
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (k < int'(ws)) begin
        row_sum = row_sum + LINE_W'(lanes_in[k]);
        if (lanes_in[k] > row_max) begin
          row_max = lanes_in[k];
        end
      end
    end
    rowval = avg_q ? row_sum : LINE_W'(row_max);
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit_c) begin
      rowval_q  <= rowval;
      lane_q    <= row_q[LANE_AW-1:0];
      hitr_q    <= hit_r;
      last_q    <= is_last;
      plane_m_q <= plane_q;
      orow_m_q  <= orow_q;
      oc_m_q    <= oc_q;
    end
  end

  // Merge the new row value into its lane, then fold the window rows down the column.
  // The column maximum starts from the most negative sample, sign-extended to a lane.
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (LANE_AW'(k) == lane_q) begin
        lane_v[k] = rowval_q;
      end else begin
        lane_v[k] = rd_data[k*LINE_W +: LINE_W];
      end
      wr_data[k*LINE_W +: LINE_W] = lane_v[k];
    end
    col_sum = '0;
    col_max = {{(LINE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sel = lane_q - LANE_AW'(i);
      if (i < int'(ws)) begin
        col_sum = col_sum + TOT_W'(lane_v[sel]);
        if (lane_v[sel] > col_max) begin
          col_max = lane_v[sel];
        end
      end
    end
    tot = avg_q ? col_sum : TOT_W'(col_max);
  end

  always_comb begin
    rd_ext = 32'(oc_q);
    wr_ext = 32'(oc_m_q);
  end

  pool2d_linemem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .WORD_W(WORD_W)
  ) u_linemem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd),
    .rd_addr_i(rd_ext[AW-1:0]),
    .rd_data_o(rd_data),
    .wr_en_i  (mem_wr),
    .wr_addr_i(wr_ext[AW-1:0]),
    .wr_data_i(wr_data)
  );

  always_comb begin
    div_req.valid = (state_q == S_MERGE) && hitr_q && avg_q;
    div_req.win   = ws;
    div_req.total = tot;
  end

  pool2d_avgdiv u_avgdiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && hit_c) begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (!hitr_q) begin
          state_d = S_IDLE;
        end else if (avg_q) begin
          state_d = S_WAIT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WAIT: begin
        if (div_rsp.valid) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mem_rd     = accept && hit_c;
    mem_wr     = (state_q == S_MERGE);
    load_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_MERGE) && hitr_q && !avg_q) begin
      res_q <= tot[SAMPLE_W-1:0];
    end else if ((state_q == S_WAIT) && div_rsp.valid) begin
      res_q <= div_rsp.quot;
    end
  end

  // Output register: the next sample can enter while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pooled_q     <= res_q;
      plane_out_q  <= plane_m_q;
      row_out_q    <= orow_m_q;
      col_out_q    <= oc_m_q;
      tensor_end_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pooled_o      = pooled_q;
  assign plane_index_o = plane_out_q;
  assign out_row_o     = row_out_q;
  assign out_col_o     = col_out_q;
  assign tensor_end_o  = tensor_end_q;

`ifndef SYNTH
  a_merge_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> ($past(state_q) == S_IDLE))
    else $error("line buffer merge without a preceding accepted sample");

  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.valid |-> (state_q == S_WAIT))
    else $error("divider result arrived outside the wait state");

  a_end_on_last_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tensor_end_o) |-> (plane_index_o == 6'(chans - 7'd1)))
    else $error("tensor end flagged on a plane that is not the last");
`endif

endmodule
